// ----- rtl/oddcp_pkg.sv -----
// Package for the ordered dither dot column packer: field widths, register
// indexes and the structs passed between the sequencer and the dot unit.
// No dependencies.
`timescale 1ns / 1ps

package oddcp_pkg;

  // fixed field widths
  localparam int ROW_W      = 16;
  localparam int LEVEL_W    = 8;
  localparam int REP_W      = 7;
  localparam int ADDR_W     = 16;
  localparam int MASK_W     = 8;
  localparam int THR_W      = 4;
  localparam int START_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // dither matrix is square, fixed at four by four
  localparam int MATRIX_SIZE = 4;

  // defaults for the top level parameters
  localparam int MAX_REPEAT_DEF  = 64;
  localparam int COLUMN_BITS_DEF = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHADE_MODE   = 3'd0,
    REG_THRESHOLD    = 3'd1,
    REG_DITHER_LOW   = 3'd2,
    REG_DITHER_HIGH  = 3'd3,
    REG_START_COLUMN = 3'd4,
    REG_PLANE0_OFS   = 3'd5,
    REG_PLANE1_OFS   = 3'd6,
    REG_PLANE2_OFS   = 3'd7
  } cfg_reg_e;

  // configuration register file
  typedef struct packed {
    logic                  shade_mode;
    logic [THR_W-1:0]      threshold;
    logic [CFG_DATA_W-1:0] dither_high;
    logic [CFG_DATA_W-1:0] dither_low;
    logic [START_W-1:0]    start_column;
    logic [ADDR_W-1:0]     plane0_offset;
    logic [ADDR_W-1:0]     plane1_offset;
    logic [ADDR_W-1:0]     plane2_offset;
  } cfg_t;

  // source pixel as held while its dots are issued
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] yellow_level;
    logic [LEVEL_W-1:0] magenta_level;
    logic [LEVEL_W-1:0] cyan_level;
    logic [LEVEL_W-1:0] black_level;
  } pixel_t;

  // one dot write without the last flag
  typedef struct packed {
    logic [ADDR_W-1:0] plane0_address;
    logic [ADDR_W-1:0] plane1_address;
    logic [ADDR_W-1:0] plane2_address;
    logic [MASK_W-1:0] bit_mask;
    logic              dot0;
    logic              dot1;
    logic              dot2;
  } dot_t;

endpackage

// ----- rtl/oddcp_if.sv -----
// Valid/ready channel interfaces for the packer: source pixel requests,
// dot write requests and configuration writes.
// Depends on oddcp_pkg.
`timescale 1ns / 1ps

interface oddcp_pix_if;
  logic                        valid;
  logic                        ready;
  logic [oddcp_pkg::ROW_W-1:0]   row;
  logic                        row_start;
  logic [oddcp_pkg::LEVEL_W-1:0] yellow_level;
  logic [oddcp_pkg::LEVEL_W-1:0] magenta_level;
  logic [oddcp_pkg::LEVEL_W-1:0] cyan_level;
  logic [oddcp_pkg::LEVEL_W-1:0] black_level;
  logic [oddcp_pkg::REP_W-1:0]   repeat_req;

  modport source (output valid, row, row_start, yellow_level, magenta_level,
                  cyan_level, black_level, repeat_req, input ready);
  modport sink   (input valid, row, row_start, yellow_level, magenta_level,
                  cyan_level, black_level, repeat_req, output ready);
endinterface

interface oddcp_dot_if;
  logic                       valid;
  logic                       ready;
  logic [oddcp_pkg::ADDR_W-1:0] plane0_address;
  logic [oddcp_pkg::ADDR_W-1:0] plane1_address;
  logic [oddcp_pkg::ADDR_W-1:0] plane2_address;
  logic [oddcp_pkg::MASK_W-1:0] bit_mask;
  logic                       dot0;
  logic                       dot1;
  logic                       dot2;
  logic                       last;

  modport source (output valid, plane0_address, plane1_address, plane2_address,
                  bit_mask, dot0, dot1, dot2, last, input ready);
  modport sink   (input valid, plane0_address, plane1_address, plane2_address,
                  bit_mask, dot0, dot1, dot2, last, output ready);
endinterface

interface oddcp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [oddcp_pkg::CFG_IDX_W-1:0]  index;
  logic [oddcp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/oddcp_dot_unit.sv -----
// Shared dot unit: dither lookup, level compares, plane addresses and bit
// mask for one printer column. Used once per cycle by the sequencer while it is not stalled.
// Depends on oddcp_pkg.
`timescale 1ns / 1ps

module oddcp_dot_unit #(
  parameter int COLUMN_BITS = oddcp_pkg::COLUMN_BITS_DEF
) (
  input  oddcp_pkg::cfg_t         cfg,
  input  oddcp_pkg::pixel_t       pixel,
  input  logic [COLUMN_BITS-1:0]  printer_column,
  input  logic [COLUMN_BITS-1:0]  mono_column,
  output oddcp_pkg::dot_t         dot
);

  localparam int MatBits = $clog2(oddcp_pkg::MATRIX_SIZE);
  localparam int IdxBits = 2 * MatBits;
  localparam int AW      = oddcp_pkg::ADDR_W;
  localparam int LW      = oddcp_pkg::LEVEL_W;

  logic [IdxBits-1:0]        dither_idx;
  logic [2*oddcp_pkg::CFG_DATA_W-1:0] dither_all;
  logic [LW-1:0]             dither_val;
  logic [LW-1:0]             mono_level;
  logic [oddcp_pkg::ROW_W-4:0] row_byte;
  logic [4:0]                digit_sum;
  logic [2:0]                fold_sum;
  logic [1:0]                band;
  logic [COLUMN_BITS-1:0]    addr_col;
  logic [AW-1:0]             col_ext;
  logic [AW-1:0]             col_x3;
  logic [AW-1:0]             band_ofs;

  // dither entry from low bits of row and printer column
  assign dither_idx = {pixel.row[MatBits-1:0], printer_column[MatBits-1:0]};
  assign dither_all = {cfg.dither_high, cfg.dither_low};
  assign dither_val = dither_all[dither_idx*LW +: LW];

  // mono level: fixed threshold inverted, or dither value when threshold is zero
  assign mono_level = (cfg.threshold != '0) ?
                      LW'(cfg.threshold ^ {oddcp_pkg::THR_W{1'b1}}) : dither_val;

  // band = (row mod 24) / 8 = (row / 8) mod 3, from base-4 digit sums
  assign row_byte = pixel.row[oddcp_pkg::ROW_W-1:3];
  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < (oddcp_pkg::ROW_W - 3 + 1) / 2; i++) begin
      if (2*i + 1 < oddcp_pkg::ROW_W - 3) begin
        digit_sum = digit_sum + 5'(row_byte[2*i +: 2]);
      end else begin
        digit_sum = digit_sum + 5'(row_byte[2*i]);
      end
    end
    fold_sum = 3'(digit_sum[1:0]) + 3'(digit_sum[3:2]) + 3'(digit_sum[4]);
    priority if (fold_sum >= 3'd6) begin
      band = 2'(fold_sum - 3'd6);
    end else if (fold_sum >= 3'd3) begin
      band = 2'(fold_sum - 3'd3);
    end else begin
      band = fold_sum[1:0];
    end
  end

  // address column times three, wrapped to the address width
  assign addr_col = cfg.shade_mode ? printer_column : mono_column;
  assign col_ext  = AW'(addr_col);
  assign col_x3   = (col_ext << 1) + col_ext;
  assign band_ofs = col_x3 + AW'(band);

  // plane addresses, mask and dot decisions
  always_comb begin
    dot.bit_mask       = oddcp_pkg::MASK_W'(8'h80 >> pixel.row[2:0]);
    dot.plane0_address = cfg.plane0_offset + band_ofs;
    if (cfg.shade_mode) begin
      dot.plane1_address = cfg.plane1_offset + band_ofs;
      dot.plane2_address = cfg.plane2_offset + band_ofs;
      dot.dot0           = pixel.yellow_level  > dither_val;
      dot.dot1           = pixel.magenta_level > dither_val;
      dot.dot2           = pixel.cyan_level    > dither_val;
    end else begin
      dot.plane1_address = '0;
      dot.plane2_address = '0;
      dot.dot0           = pixel.black_level > mono_level;
      dot.dot1           = 1'b0;
      dot.dot2           = 1'b0;
    end
  end

endmodule

// ----- rtl/ordered_dither_dot_column_packer.sv -----
// Top level of the ordered dither dot column packer: configuration
// registers, column counters and the dot sequencer.
// Depends on oddcp_pkg, oddcp_if and oddcp_dot_unit.
`timescale 1ns / 1ps

// Each source pixel request is expanded into one dot write request per
// printer column it covers (repeat_req, zero taken as one, capped at
// MAX_REPEAT). A pixel is taken while the sequencer is idle and its dots then
// leave one per cycle from the output register while the sink keeps up; the
// input is not ready again until the final dot of the pixel is issued, and
// sink stalls hold the sequencer. The rate is set by the single shared dot
// unit, which works out one printer column per cycle. The next pixel is taken
// while the final dot still waits in the output register. Configuration writes
// are always accepted and must only be made while no pixel is in progress.
module ordered_dither_dot_column_packer #(
  parameter int MAX_REPEAT  = oddcp_pkg::MAX_REPEAT_DEF,
  parameter int COLUMN_BITS = oddcp_pkg::COLUMN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  oddcp_pix_if.sink     pix,
  oddcp_dot_if.source   dot,
  oddcp_cfg_if.sink     cfg
);

  localparam int CntW = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
  localparam int RW   = oddcp_pkg::REP_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                 state;
  state_t                 state_next;
  oddcp_pkg::cfg_t        cfg_regs;
  oddcp_pkg::pixel_t      pixel;
  oddcp_pkg::dot_t        unit_dot;
  oddcp_pkg::dot_t        out_dot;
  logic                   out_valid;
  logic                   out_last;
  logic [COLUMN_BITS-1:0] printer_column;
  logic [COLUMN_BITS-1:0] mono_column;
  logic [CntW-1:0]        count;
  logic [CntW-1:0]        rep_last;
  logic [RW-1:0]          rep_eff;
  logic                   pix_take;
  logic                   issue;
  logic                   issue_last;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (oddcp_pkg::cfg_reg_e'(cfg.index))
        oddcp_pkg::REG_SHADE_MODE:   cfg_regs.shade_mode    <= cfg.data[0];
        oddcp_pkg::REG_THRESHOLD:    cfg_regs.threshold     <= cfg.data[oddcp_pkg::THR_W-1:0];
        oddcp_pkg::REG_DITHER_LOW:   cfg_regs.dither_low    <= cfg.data;
        oddcp_pkg::REG_DITHER_HIGH:  cfg_regs.dither_high   <= cfg.data;
        oddcp_pkg::REG_START_COLUMN: cfg_regs.start_column  <= cfg.data[oddcp_pkg::START_W-1:0];
        oddcp_pkg::REG_PLANE0_OFS:   cfg_regs.plane0_offset <= cfg.data[oddcp_pkg::ADDR_W-1:0];
        oddcp_pkg::REG_PLANE1_OFS:   cfg_regs.plane1_offset <= cfg.data[oddcp_pkg::ADDR_W-1:0];
        oddcp_pkg::REG_PLANE2_OFS:   cfg_regs.plane2_offset <= cfg.data[oddcp_pkg::ADDR_W-1:0];
      endcase
    end
  end

  // handshake and sequencing controls
  assign pix.ready  = (state == ST_IDLE);
  assign pix_take   = pix.valid && pix.ready;
  assign issue      = (state == ST_RUN) && (!out_valid || dot.ready);
  assign issue_last = (count == rep_last);

  // effective repeat: zero as one, saturated at the maximum
  always_comb begin
    priority if (pix.repeat_req == '0) begin
      rep_eff = RW'(1);
    end else if (pix.repeat_req > RW'(MAX_REPEAT)) begin
      rep_eff = RW'(MAX_REPEAT);
    end else begin
      rep_eff = pix.repeat_req;
    end
  end

  // sequencer state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pix_take) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (issue && issue_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel hold and column repeat counter
  always_ff @(posedge clk) begin
    if (pix_take) begin
      pixel.row           <= pix.row;
      pixel.yellow_level  <= pix.yellow_level;
      pixel.magenta_level <= pix.magenta_level;
      pixel.cyan_level    <= pix.cyan_level;
      pixel.black_level   <= pix.black_level;
      rep_last            <= CntW'(rep_eff - RW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (pix_take) begin
      count <= '0;
    end else if (issue) begin
      count <= count + CntW'(1);
    end
  end

  // column counters: reload on row start, advance per dot issued
  always_ff @(posedge clk) begin
    if (rst) begin
      printer_column <= '0;
      mono_column    <= '0;
    end else if (pix_take && pix.row_start) begin
      printer_column <= COLUMN_BITS'(cfg_regs.start_column);
      mono_column    <= '0;
    end else if (issue) begin
      printer_column <= printer_column + COLUMN_BITS'(1);
      mono_column    <= mono_column + COLUMN_BITS'(1);
    end
  end

  // shared dot unit
  oddcp_dot_unit #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dot (
    .cfg            (cfg_regs),
    .pixel          (pixel),
    .printer_column (printer_column),
    .mono_column    (mono_column),
    .dot            (unit_dot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (dot.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_dot  <= unit_dot;
      out_last <= issue_last;
    end
  end

  assign dot.valid          = out_valid;
  assign dot.plane0_address = out_dot.plane0_address;
  assign dot.plane1_address = out_dot.plane1_address;
  assign dot.plane2_address = out_dot.plane2_address;
  assign dot.bit_mask       = out_dot.bit_mask;
  assign dot.dot0           = out_dot.dot0;
  assign dot.dot1           = out_dot.dot1;
  assign dot.dot2           = out_dot.dot2;
  assign dot.last           = out_last;

`ifndef NO_ASSERTIONS
  // a new dot request only appears while a pixel is being worked
  a_rose_in_run: assert property (@(posedge clk) disable iff (rst)
    $rose(dot.valid) |-> $past(state == ST_RUN))
    else $error("dot request raised outside a pixel");

  // the final dot of a pixel returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (state == ST_IDLE) && dot.valid && dot.last)
    else $error("final dot did not close the pixel");

  // every issued dot advances the printer column by one
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    issue |=> printer_column == COLUMN_BITS'($past(printer_column) + COLUMN_BITS'(1)))
    else $error("printer column did not advance");

  // a row start reloads both column counters
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    (pix_take && pix.row_start) |=>
      (printer_column == COLUMN_BITS'($past(cfg_regs.start_column))) &&
      (mono_column == '0))
    else $error("row start did not reload the columns");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for ordered_dither_dot_column_packer: directed table then
// random rows under bursty source and stalling sink, each dot write checked against a predictor or the table.
// Depends on oddcp_pkg, oddcp_if and the packer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_REPEAT    = oddcp_pkg::MAX_REPEAT_DEF;
  localparam int COL_W         = oddcp_pkg::COLUMN_BITS_DEF;
  localparam int ROW_W         = oddcp_pkg::ROW_W;
  localparam int LEVEL_W       = oddcp_pkg::LEVEL_W;
  localparam int REP_W         = oddcp_pkg::REP_W;
  localparam int ADDR_W        = oddcp_pkg::ADDR_W;
  localparam int MASK_W        = oddcp_pkg::MASK_W;
  localparam int THR_W         = oddcp_pkg::THR_W;
  localparam int START_W       = oddcp_pkg::START_W;
  localparam int CFG_DATA_W    = oddcp_pkg::CFG_DATA_W;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 45;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SHOW_LIMIT    = 10;

  // 4x4 bayer matrix scaled to 0..240, byte i at bits 8i
  localparam logic [CFG_DATA_W-1:0] BAYER_LOW  = 64'h60E0_40C0_A020_8000;
  localparam logic [CFG_DATA_W-1:0] BAYER_HIGH = 64'h50D0_70F0_9010_B030;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic               row_start;
    logic [LEVEL_W-1:0] yellow;
    logic [LEVEL_W-1:0] magenta;
    logic [LEVEL_W-1:0] cyan;
    logic [LEVEL_W-1:0] black;
    logic [REP_W-1:0]   reps;
  } pix_req_t;

  typedef struct packed {
    oddcp_pkg::dot_t d;
    logic            last;
  } dot_write_t;

  // a dot write typed into the table, used instead of the predicted one
  typedef struct packed {
    logic       fixed;
    dot_write_t want;
  } table_dot_t;

  typedef struct {
    int         phase;
    pix_req_t   px;
    table_dot_t check;
  } stim_row_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_CHOKED} sink_mode_e;

  logic clk;
  logic rst;

  oddcp_pix_if pix();
  oddcp_dot_if dot();
  oddcp_cfg_if cfg();

  ordered_dither_dot_column_packer #(
    .MAX_REPEAT (MAX_REPEAT),
    .COLUMN_BITS(COL_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .dot(dot),
    .cfg(cfg)
  );

  // predictor state: register copy and the two column counters
  oddcp_pkg::cfg_t  shadow    = '0;
  logic [COL_W-1:0] print_col = '0;
  logic [COL_W-1:0] mono_col  = '0;

  dot_write_t      pending_dots[$];
  table_dot_t      table_dots[$];
  stim_row_t       directed_rows[$];
  oddcp_pkg::cfg_t phase_cfg[6];

  int unsigned pixels_issued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned fault_count   = 0;
  int          burst_left    = 0;
  bit          keen          = 0;

  sink_mode_e  sink_mode = SINK_OPEN;
  int          mode_left = 0;
  int unsigned sink_tick = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] plane_addr(logic [ADDR_W-1:0] ofs, logic [1:0] band,
                                                   logic [COL_W-1:0] col);
    return ofs + ADDR_W'(band) + ADDR_W'(col) * 16'd3;
  endfunction

  // expand one source pixel into its expected dot writes
  function automatic void expand_pixel(pix_req_t p, table_dot_t side);
    int unsigned      n;
    logic [3:0]       mat_idx;
    logic [63:0]      word;
    logic [7:0]       dv;
    logic [7:0]       level;
    logic [1:0]       band;
    dot_write_t       w;
    n = p.reps;
    if (n == 0) n = 1;
    if (n > MAX_REPEAT) n = MAX_REPEAT;
    band = 2'((p.row % 24) >> 3);
    if (p.row_start) begin
      print_col = shadow.start_column;
      mono_col  = '0;
    end
    for (int k = 0; k < n; k++) begin
      mat_idx = {p.row[1:0], print_col[1:0]};
      word    = mat_idx[3] ? shadow.dither_high : shadow.dither_low;
      dv      = word[8*mat_idx[2:0] +: 8];
      w       = '0;
      w.d.bit_mask = 8'h80 >> p.row[2:0];
      w.last       = (k == n - 1);
      if (shadow.shade_mode) begin
        w.d.plane0_address = plane_addr(shadow.plane0_offset, band, print_col);
        w.d.plane1_address = plane_addr(shadow.plane1_offset, band, print_col);
        w.d.plane2_address = plane_addr(shadow.plane2_offset, band, print_col);
        w.d.dot0 = p.yellow > dv;
        w.d.dot1 = p.magenta > dv;
        w.d.dot2 = p.cyan > dv;
      end else begin
        level = (shadow.threshold != 0) ? {4'd0, shadow.threshold ^ 4'hF} : dv;
        w.d.plane0_address = plane_addr(shadow.plane0_offset, band, mono_col);
        w.d.dot0 = p.black > level;
      end
      if (!side.fixed) pending_dots.push_back(w);
      print_col = print_col + 1'b1;
      mono_col  = mono_col + 1'b1;
    end
    if (side.fixed) pending_dots.push_back(side.want);
  endfunction

  function automatic string show_dot(dot_write_t w);
    return $sformatf("a0=%h a1=%h a2=%h mask=%h dots=%b%b%b last=%b",
                     w.d.plane0_address, w.d.plane1_address, w.d.plane2_address,
                     w.d.bit_mask, w.d.dot0, w.d.dot1, w.d.dot2, w.last);
  endfunction

  function automatic void log_fault(string msg);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) $display("%0t  %s", $time, msg);
  endfunction

  // scoreboard: dot writes, register writes, pixel requests
  always @(posedge clk) begin : watch
    dot_write_t got;
    dot_write_t want;
    pix_req_t   px;
    table_dot_t side;
    string      diff;
    if (!rst) begin
      if (dot.valid && dot.ready) begin
        got.d.plane0_address = dot.plane0_address;
        got.d.plane1_address = dot.plane1_address;
        got.d.plane2_address = dot.plane2_address;
        got.d.bit_mask       = dot.bit_mask;
        got.d.dot0           = dot.dot0;
        got.d.dot1           = dot.dot1;
        got.d.dot2           = dot.dot2;
        got.last             = dot.last;
        if (pending_dots.size() == 0) begin
          log_fault({"dot write with none expected: ", show_dot(got)});
        end else begin
          want = pending_dots.pop_front();
          diff = "";
          if (got.d.plane0_address !== want.d.plane0_address) diff = {diff, " plane0_address"};
          if (got.d.plane1_address !== want.d.plane1_address) diff = {diff, " plane1_address"};
          if (got.d.plane2_address !== want.d.plane2_address) diff = {diff, " plane2_address"};
          if (got.d.bit_mask !== want.d.bit_mask) diff = {diff, " bit_mask"};
          if (got.d.dot0 !== want.d.dot0) diff = {diff, " dot0"};
          if (got.d.dot1 !== want.d.dot1) diff = {diff, " dot1"};
          if (got.d.dot2 !== want.d.dot2) diff = {diff, " dot2"};
          if (got.last !== want.last) diff = {diff, " last"};
          if (diff != "")
            log_fault($sformatf("mismatch on%s\n  expected %s\n  actual   %s",
                                diff, show_dot(want), show_dot(got)));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          oddcp_pkg::REG_SHADE_MODE:   shadow.shade_mode    = cfg.data[0];
          oddcp_pkg::REG_THRESHOLD:    shadow.threshold     = cfg.data[THR_W-1:0];
          oddcp_pkg::REG_DITHER_LOW:   shadow.dither_low    = cfg.data;
          oddcp_pkg::REG_DITHER_HIGH:  shadow.dither_high   = cfg.data;
          oddcp_pkg::REG_START_COLUMN: shadow.start_column  = cfg.data[START_W-1:0];
          oddcp_pkg::REG_PLANE0_OFS:   shadow.plane0_offset = cfg.data[ADDR_W-1:0];
          oddcp_pkg::REG_PLANE1_OFS:   shadow.plane1_offset = cfg.data[ADDR_W-1:0];
          oddcp_pkg::REG_PLANE2_OFS:   shadow.plane2_offset = cfg.data[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        px.row       = pix.row;
        px.row_start = pix.row_start;
        px.yellow    = pix.yellow_level;
        px.magenta   = pix.magenta_level;
        px.cyan      = pix.cyan_level;
        px.black     = pix.black_level;
        px.reps      = pix.repeat_req;
        side = table_dots.pop_front();
        expand_pixel(px, side);
        pixels_taken++;
      end
    end
  end

  // sink stall pattern, switching between open, random, periodic and choked spells
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      SINK_OPEN:     dot.ready <= 1'b1;
      SINK_RANDOM:   dot.ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: dot.ready <= ((sink_tick % 5) < 3);
      default:       dot.ready <= ((sink_tick % 9) == 0);
    endcase
    sink_tick++;
  end

  function automatic logic [CFG_DATA_W-1:0] reg_data(oddcp_pkg::cfg_t c,
                                                     oddcp_pkg::cfg_reg_e r);
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    case (r)
      oddcp_pkg::REG_SHADE_MODE:   v[0]           = c.shade_mode;
      oddcp_pkg::REG_THRESHOLD:    v[THR_W-1:0]   = c.threshold;
      oddcp_pkg::REG_DITHER_LOW:   v              = c.dither_low;
      oddcp_pkg::REG_DITHER_HIGH:  v              = c.dither_high;
      oddcp_pkg::REG_START_COLUMN: v[START_W-1:0] = c.start_column;
      oddcp_pkg::REG_PLANE0_OFS:   v[ADDR_W-1:0]  = c.plane0_offset;
      oddcp_pkg::REG_PLANE1_OFS:   v[ADDR_W-1:0]  = c.plane1_offset;
      oddcp_pkg::REG_PLANE2_OFS:   v[ADDR_W-1:0]  = c.plane2_offset;
      default: ;
    endcase
    return v;
  endfunction

  // write every register back to back
  task automatic program_regs(oddcp_pkg::cfg_t c);
    oddcp_pkg::cfg_reg_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg.valid <= 1'b1;
      cfg.index <= r;
      cfg.data  <= reg_data(c, r);
      do @(posedge clk); while (!cfg.ready);
      r = r.next();
    end
    cfg.valid <= 1'b0;
  endtask

  // drop valid and wait until every pixel is taken and every dot write seen
  task automatic settle();
    pix.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pixels_taken != pixels_issued || pending_dots.size() != 0);
  endtask

  // one pixel request, with a random gap between bursts
  task automatic send_pixel(pix_req_t p, table_dot_t side);
    int gap;
    if (burst_left == 0) begin
      gap = (keen || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    table_dots.push_back(side);
    pix.valid         <= 1'b1;
    pix.row           <= p.row;
    pix.row_start     <= p.row_start;
    pix.yellow_level  <= p.yellow;
    pix.magenta_level <= p.magenta;
    pix.cyan_level    <= p.cyan;
    pix.black_level   <= p.black;
    pix.repeat_req    <= p.reps;
    do @(posedge clk); while (!pix.ready);
    burst_left--;
    pixels_issued++;
  endtask

  function automatic void add_row(int ph, logic [ROW_W-1:0] row, logic rs,
                                  logic [7:0] y, logic [7:0] m, logic [7:0] c,
                                  logic [7:0] k, logic [REP_W-1:0] n,
                                  table_dot_t side = '0);
    stim_row_t s;
    s.phase = ph;
    s.px    = '{row: row, row_start: rs, yellow: y, magenta: m, cyan: c, black: k, reps: n};
    s.check = side;
    directed_rows.push_back(s);
  endfunction

  // single mono dot write, final of its pixel
  function automatic table_dot_t mono_want(logic [ADDR_W-1:0] a0, logic [MASK_W-1:0] msk,
                                           logic d0);
    table_dot_t t;
    t = '0;
    t.fixed                  = 1'b1;
    t.want.d.plane0_address  = a0;
    t.want.d.bit_mask        = msk;
    t.want.d.dot0            = d0;
    t.want.last              = 1'b1;
    return t;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly short repeats, a few long and a few past the cap
  function automatic logic [REP_W-1:0] pick_reps();
    int d;
    d = $urandom_range(0, 99);
    if (d < 70) return REP_W'($urandom_range(0, 3));
    if (d < 90) return REP_W'($urandom_range(4, 16));
    if (d < 98) return REP_W'($urandom_range(17, 64));
    return REP_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'hFFFF - 16'($urandom_range(0, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic oddcp_pkg::cfg_t pick_setting();
    oddcp_pkg::cfg_t c;
    c.shade_mode = 1'($urandom);
    case ($urandom_range(0, 3))
      0:       c.threshold = '0;
      1:       c.threshold = 4'hF;
      default: c.threshold = 4'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: begin
        c.dither_low  = '0;
        c.dither_high = '0;
      end
      1: begin
        c.dither_low  = '1;
        c.dither_high = '1;
      end
      default: begin
        c.dither_low  = {$urandom, $urandom};
        c.dither_high = {$urandom, $urandom};
      end
    endcase
    case ($urandom_range(0, 3))
      0:       c.start_column = '0;
      1:       c.start_column = '1;
      default: c.start_column = 12'($urandom);
    endcase
    c.plane0_offset = pick_offset();
    c.plane1_offset = pick_offset();
    c.plane2_offset = pick_offset();
    return c;
  endfunction

  // main sequence
  initial begin : stimulus
    int               cur;
    int               sent;
    int               run_len;
    pix_req_t         px;
    logic [ROW_W-1:0] line_row;

    rst               <= 1'b1;
    pix.valid         <= 1'b0;
    pix.row           <= '0;
    pix.row_start     <= 1'b0;
    pix.yellow_level  <= '0;
    pix.magenta_level <= '0;
    pix.cyan_level    <= '0;
    pix.black_level   <= '0;
    pix.repeat_req    <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= oddcp_pkg::REG_SHADE_MODE;
    cfg.data          <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // register settings for the directed phases, phase 0 is the reset state
    phase_cfg[0] = '0;
    phase_cfg[1] = '{shade_mode: 1'b1, threshold: 4'd0, dither_high: BAYER_HIGH,
                     dither_low: BAYER_LOW, start_column: 12'hFFF, plane0_offset: 16'hFFFF,
                     plane1_offset: 16'hFFF0, plane2_offset: 16'h8000};
    phase_cfg[2] = '{shade_mode: 1'b1, threshold: 4'd0, dither_high: '0, dither_low: '1,
                     start_column: 12'h000, plane0_offset: 16'h0000,
                     plane1_offset: 16'h1234, plane2_offset: 16'hFFFF};
    phase_cfg[3] = '{shade_mode: 1'b0, threshold: 4'hF, dither_high: BAYER_HIGH,
                     dither_low: BAYER_LOW, start_column: 12'd100, plane0_offset: 16'hFFFE,
                     plane1_offset: 16'h0000, plane2_offset: 16'h0000};
    phase_cfg[4] = '{shade_mode: 1'b0, threshold: 4'd0, dither_high: BAYER_HIGH,
                     dither_low: BAYER_LOW, start_column: 12'd2, plane0_offset: 16'hFFFF,
                     plane1_offset: 16'hAAAA, plane2_offset: 16'h5555};
    phase_cfg[5] = '{shade_mode: 1'b0, threshold: 4'd1, dither_high: '0, dither_low: '1,
                     start_column: 12'hFFF, plane0_offset: 16'h1000,
                     plane1_offset: 16'hFFFF, plane2_offset: 16'hFFFF};

    // reset state: mono, dithered grey with an all-zero matrix, zero offsets
    add_row(0, 16'd0,    1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0,
            mono_want(16'h0000, 8'h80, 1'b0));
    add_row(0, 16'd7,    1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd1,
            mono_want(16'h0003, 8'h01, 1'b1));
    add_row(0, 16'd23,   1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 7'd1,
            mono_want(16'h0002, 8'h01, 1'b1));
    add_row(0, 16'hFFFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 7'd1,
            mono_want(16'h0004, 8'h01, 1'b0));
    // colour, column wrapping from 4095, full repeat and repeat past the cap
    add_row(1, 16'd0,    1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 7'd64);
    add_row(1, 16'd1,    1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd127);
    add_row(1, 16'd2,    1'b0, 8'h80, 8'h00, 8'hC8, 8'h55, 7'd3);
    add_row(1, 16'd24,   1'b1, 8'h21, 8'hA1, 8'hF1, 8'h00, 7'd65);
    // colour against an all-ones and an all-zero matrix half
    add_row(2, 16'd8,    1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 7'd2);
    add_row(2, 16'd10,   1'b0, 8'h01, 8'h00, 8'hFF, 8'h00, 7'd2);
    add_row(2, 16'hFFFF, 1'b0, 8'h7F, 8'h80, 8'hFE, 8'h00, 7'd0);
    // fixed threshold at the top level, so any non-zero black sets a dot
    add_row(3, 16'd5,    1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 7'd4);
    add_row(3, 16'd5,    1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h01, 7'd1);
    add_row(3, 16'd16,   1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd2);
    // dithered grey, then a new row without its row start
    add_row(4, 16'd3,    1'b1, 8'h00, 8'h00, 8'h00, 8'hF0, 7'd4);
    add_row(4, 16'd3,    1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd4);
    add_row(4, 16'd0,    1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 7'd1);
    // lowest non-zero threshold, black at and just above level 14
    add_row(5, 16'd9,    1'b1, 8'h00, 8'h00, 8'h00, 8'd14, 7'd1);
    add_row(5, 16'd9,    1'b0, 8'h00, 8'h00, 8'h00, 8'd15, 7'd1);
    add_row(5, 16'd40,   1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 7'd64);

    // directed table
    cur = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].phase != cur) begin
        settle();
        cur = directed_rows[i].phase;
        program_regs(phase_cfg[cur]);
        keen = ($urandom_range(0, 3) == 0);
      end
      send_pixel(directed_rows[i].px, directed_rows[i].check);
    end

    // random phases: printer rows opened by a row start, with some noise
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      program_regs(pick_setting());
      keen = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        line_row = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(0, 47));
        run_len  = $urandom_range(1, 8);
        for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++) begin
          px.row       = line_row;
          px.row_start = (j == 0);
          if ($urandom_range(0, 9) == 0) begin
            px.row       = ROW_W'($urandom);
            px.row_start = 1'($urandom);
          end
          px.yellow  = pick_level();
          px.magenta = pick_level();
          px.cyan    = pick_level();
          px.black   = pick_level();
          px.reps    = pick_reps();
          send_pixel(px, '0);
          sent++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
